// ===== rtl/ptc_pkg.sv =====
// Shared types and constants for the pressure and temperature compensation pipeline.
// Used by every module under rtl; depends on nothing else.
package ptc_pkg;

    localparam int IDX_W  = 3;
    localparam int T_W    = 19;
    localparam int OFF_W  = 36;
    localparam int SENS_W = 35;
    localparam int T2_W   = 17;
    localparam int TC_W   = 20;
    localparam int OFFF_W = 40;
    localparam int SENSF_W = 39;

    localparam logic [IDX_W-1:0] REG_CAL_SENS      = 3'd0;
    localparam logic [IDX_W-1:0] REG_CAL_OFFSET    = 3'd1;
    localparam logic [IDX_W-1:0] REG_CAL_SENS_TC   = 3'd2;
    localparam logic [IDX_W-1:0] REG_CAL_OFFSET_TC = 3'd3;
    localparam logic [IDX_W-1:0] REG_CAL_TREF      = 3'd4;
    localparam logic [IDX_W-1:0] REG_CAL_TEMPSENS  = 3'd5;
    localparam logic [IDX_W-1:0] REG_PRESS_TRIM    = 3'd6;
    localparam logic [IDX_W-1:0] REG_TEMP_TRIM     = 3'd7;

    localparam logic [31:0] NO_TRIM = 32'hFFFF_FFFF;

    localparam logic signed [T_W-1:0] T_BASE = 19'sd2000;
    localparam logic signed [T_W-1:0] T_COLD = -19'sd1500;

    typedef struct packed {
        logic [15:0] sens;
        logic [15:0] offset;
        logic [15:0] sens_tc;
        logic [15:0] offset_tc;
        logic [15:0] tref;
        logic [15:0] tempsens;
        logic [31:0] press_trim;
        logic [31:0] temp_trim;
    } ptc_cfg_t;

    typedef struct packed {
        logic [23:0]              d1;
        logic signed [T_W-1:0]    t;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
        logic [T2_W-1:0]          t2_cold;
        logic [T2_W-1:0]          t2_warm;
    } ptc_first_t;

    typedef struct packed {
        logic [23:0]               d1;
        logic signed [TC_W-1:0]    tc;
        logic signed [OFFF_W-1:0]  off_f;
        logic signed [SENSF_W-1:0] sens_f;
    } ptc_second_t;

endpackage

// ===== rtl/ptc_regs.sv =====
// Calibration and trim register file written through the configuration channel.
// Depends on ptc_pkg for the register codes and the configuration struct.
module ptc_regs (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic [ptc_pkg::IDX_W-1:0] cfg_index,
    input  logic [31:0]              cfg_data,
    output ptc_pkg::ptc_cfg_t        cfg
);
    import ptc_pkg::*;

    ptc_cfg_t cfg_reg;
    ptc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CAL_SENS:      cfg_next.sens       = cfg_data[15:0];
                REG_CAL_OFFSET:    cfg_next.offset     = cfg_data[15:0];
                REG_CAL_SENS_TC:   cfg_next.sens_tc    = cfg_data[15:0];
                REG_CAL_OFFSET_TC: cfg_next.offset_tc  = cfg_data[15:0];
                REG_CAL_TREF:      cfg_next.tref       = cfg_data[15:0];
                REG_CAL_TEMPSENS:  cfg_next.tempsens   = cfg_data[15:0];
                REG_PRESS_TRIM:    cfg_next.press_trim = cfg_data;
                REG_TEMP_TRIM:     cfg_next.temp_trim  = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sens       <= 16'h0000;
            cfg_reg.offset     <= 16'h0000;
            cfg_reg.sens_tc    <= 16'h0000;
            cfg_reg.offset_tc  <= 16'h0000;
            cfg_reg.tref       <= 16'h0000;
            cfg_reg.tempsens   <= 16'h0000;
            cfg_reg.press_trim <= NO_TRIM;
            cfg_reg.temp_trim  <= NO_TRIM;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/ptc_front.sv =====
// First-order stages: temperature difference, calibration products, T, OFF and SENS.
// Depends on ptc_pkg for the configuration and stage payload structs.
module ptc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  ptc_pkg::ptc_cfg_t   cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [23:0]         raw_press,
    input  logic [23:0]         raw_temp,
    output logic                out_valid,
    input  logic                out_ready,
    output ptc_pkg::ptc_first_t out_data
);
    import ptc_pkg::*;

    logic [2:0] vld_reg;
    logic [2:0] vld_next;
    logic [2:0] stg_en;

    logic signed [24:0] dt_reg;
    logic signed [24:0] dt_next;
    logic [23:0]        d1a_reg;

    logic signed [41:0] p6_reg;
    logic signed [41:0] p6_next;
    logic signed [41:0] p4_reg;
    logic signed [41:0] p4_next;
    logic signed [41:0] p3_reg;
    logic signed [41:0] p3_next;
    logic signed [49:0] dsq_full;
    logic [47:0]        dsq_reg;
    logic [23:0]        d1b_reg;

    logic signed [41:0] p6_adj;
    logic signed [41:0] p4_adj;
    logic signed [41:0] p3_adj;
    logic signed [41:0] t_shift;
    logic signed [41:0] off_shift;
    logic signed [41:0] sens_shift;
    logic [49:0]        dsq3;
    ptc_first_t         first_reg;
    ptc_first_t         first_next;

    assign stg_en[2] = !vld_reg[2] || out_ready;
    assign stg_en[1] = !vld_reg[1] || stg_en[2];
    assign stg_en[0] = !vld_reg[0] || stg_en[1];

    always_comb
    begin
        vld_next = vld_reg;
        if (stg_en[0])
            vld_next[0] = in_valid;
        if (stg_en[1])
            vld_next[1] = vld_reg[0];
        if (stg_en[2])
            vld_next[2] = vld_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 3'b000;
        else
            vld_reg <= vld_next;
    end

    assign dt_next = $signed({1'b0, raw_temp}) - $signed({1'b0, cfg.tref, 8'h00});

    assign p6_next  = dt_reg * $signed({1'b0, cfg.tempsens});
    assign p4_next  = dt_reg * $signed({1'b0, cfg.offset_tc});
    assign p3_next  = dt_reg * $signed({1'b0, cfg.sens_tc});
    assign dsq_full = dt_reg * dt_reg;

    // Signed divisions by powers of two round toward zero, so negative values get a bias.
    always_comb
    begin
        p6_adj     = p6_reg + (p6_reg[41] ? 42'sd8388607 : 42'sd0);
        p4_adj     = p4_reg + (p4_reg[41] ? 42'sd127 : 42'sd0);
        p3_adj     = p3_reg + (p3_reg[41] ? 42'sd255 : 42'sd0);
        t_shift    = p6_adj >>> 23;
        off_shift  = p4_adj >>> 7;
        sens_shift = p3_adj >>> 8;
        dsq3       = {2'b00, dsq_reg} + {1'b0, dsq_reg, 1'b0};

        first_next.d1      = d1b_reg;
        first_next.t       = t_shift[T_W-1:0] + T_BASE;
        first_next.off     = {4'b0000, cfg.offset, 16'h0000} + off_shift[OFF_W-1:0];
        first_next.sens    = {4'b0000, cfg.sens, 15'h0000} + sens_shift[SENS_W-1:0];
        first_next.t2_cold = dsq3[49:33];
        first_next.t2_warm = {5'b00000, dsq_reg[47:36]};
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[0])
        begin
            dt_reg  <= dt_next;
            d1a_reg <= raw_press;
        end
        if (stg_en[1])
        begin
            p6_reg  <= p6_next;
            p4_reg  <= p4_next;
            p3_reg  <= p3_next;
            dsq_reg <= dsq_full[47:0];
            d1b_reg <= d1a_reg;
        end
        if (stg_en[2])
            first_reg <= first_next;
    end

    assign in_ready  = stg_en[0];
    assign out_valid = vld_reg[2];
    assign out_data  = first_reg;

endmodule

// ===== rtl/ptc_second.sv =====
// Second-order correction stages: band selection, squared terms, OFF2 and SENS2.
// Depends on ptc_pkg for the stage payload structs and temperature band limits.
module ptc_second (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ptc_pkg::ptc_first_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ptc_pkg::ptc_second_t out_data
);
    import ptc_pkg::*;

    logic [2:0] vld_reg;
    logic [2:0] vld_next;
    logic [2:0] stg_en;

    logic signed [TC_W-1:0] t_ext;
    logic signed [TC_W-1:0] dlo;
    logic signed [TC_W-1:0] dvl;
    logic signed [39:0]     dsq_full;
    logic signed [39:0]     vsq_full;
    logic [T2_W-1:0]        t2_sel;
    logic                   warm_next;
    logic                   cold_next;
    logic signed [TC_W-1:0] tc_next;

    logic [34:0]              dsq_reg;
    logic [34:0]              vsq_reg;
    logic                     warm_reg;
    logic                     cold_reg;
    logic signed [TC_W-1:0]   tca_reg;
    logic signed [OFF_W-1:0]  offa_reg;
    logic signed [SENS_W-1:0] sensa_reg;
    logic [23:0]              d1a_reg;

    logic [38:0]              off2_next;
    logic [37:0]              sens2_next;
    logic [38:0]              off2_reg;
    logic [37:0]              sens2_reg;
    logic signed [TC_W-1:0]   tcb_reg;
    logic signed [OFF_W-1:0]  offb_reg;
    logic signed [SENS_W-1:0] sensb_reg;
    logic [23:0]              d1b_reg;

    ptc_second_t second_reg;
    ptc_second_t second_next;

    assign stg_en[2] = !vld_reg[2] || out_ready;
    assign stg_en[1] = !vld_reg[1] || stg_en[2];
    assign stg_en[0] = !vld_reg[0] || stg_en[1];

    always_comb
    begin
        vld_next = vld_reg;
        if (stg_en[0])
            vld_next[0] = in_valid;
        if (stg_en[1])
            vld_next[1] = vld_reg[0];
        if (stg_en[2])
            vld_next[2] = vld_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 3'b000;
        else
            vld_reg <= vld_next;
    end

    always_comb
    begin
        t_ext     = {in_data.t[T_W-1], in_data.t};
        dlo       = t_ext - TC_W'(T_BASE);
        dvl       = t_ext - TC_W'(T_COLD);
        dsq_full  = dlo * dlo;
        vsq_full  = dvl * dvl;
        warm_next = !($signed(in_data.t) < T_BASE);
        cold_next = $signed(in_data.t) < T_COLD;
        t2_sel    = warm_next ? in_data.t2_warm : in_data.t2_cold;
        tc_next   = t_ext - $signed({3'b000, t2_sel});
    end

    // Each product is truncated on its own before the cold-band terms are added.
    always_comb
    begin
        if (!warm_reg)
        begin
            off2_next  = ({3'b000, dsq_reg, 1'b0} + {4'b0000, dsq_reg}) >> 1;
            sens2_next = ({1'b0, dsq_reg, 2'b00} + {3'b000, dsq_reg}) >> 3;
            if (cold_reg)
            begin
                off2_next  = off2_next + ({1'b0, vsq_reg, 3'b000} - {4'b0000, vsq_reg});
                sens2_next = sens2_next + {1'b0, vsq_reg, 2'b00};
            end
        end
        else
        begin
            off2_next  = {4'b0000, dsq_reg} >> 4;
            sens2_next = 38'd0;
        end
    end

    always_comb
    begin
        second_next.d1     = d1b_reg;
        second_next.tc     = tcb_reg;
        second_next.off_f  = $signed({{(OFFF_W-OFF_W){offb_reg[OFF_W-1]}}, offb_reg})
                             - $signed({1'b0, off2_reg});
        second_next.sens_f = $signed({{(SENSF_W-SENS_W){sensb_reg[SENS_W-1]}}, sensb_reg})
                             - $signed({1'b0, sens2_reg});
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[0])
        begin
            dsq_reg   <= dsq_full[34:0];
            vsq_reg   <= vsq_full[34:0];
            warm_reg  <= warm_next;
            cold_reg  <= cold_next;
            tca_reg   <= tc_next;
            offa_reg  <= in_data.off;
            sensa_reg <= in_data.sens;
            d1a_reg   <= in_data.d1;
        end
        if (stg_en[1])
        begin
            off2_reg  <= off2_next;
            sens2_reg <= sens2_next;
            tcb_reg   <= tca_reg;
            offb_reg  <= offa_reg;
            sensb_reg <= sensa_reg;
            d1b_reg   <= d1a_reg;
        end
        if (stg_en[2])
            second_reg <= second_next;
    end

    assign in_ready  = stg_en[0];
    assign out_valid = vld_reg[2];
    assign out_data  = second_reg;

endmodule

// ===== rtl/ptc_press.sv =====
// Final stages: split pressure multiply, scaling, offset subtraction and trim addition.
// Depends on ptc_pkg for the configuration struct, payload struct and trim code.
module ptc_press (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ptc_pkg::ptc_cfg_t    cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ptc_pkg::ptc_second_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   temperature,
    output logic signed [31:0]   pressure
);
    import ptc_pkg::*;

    logic [3:0] vld_reg;
    logic [3:0] vld_next;
    logic [3:0] stg_en;

    logic [42:0]              pp_lo_next;
    logic signed [43:0]       pp_hi_next;
    logic [42:0]              pp_lo_reg;
    logic signed [43:0]       pp_hi_reg;
    logic signed [OFFF_W-1:0] offa_reg;
    logic signed [TC_W-1:0]   tca_reg;

    logic signed [62:0]       prod_next;
    logic signed [62:0]       prod_reg;
    logic signed [OFFF_W-1:0] offb_reg;
    logic signed [TC_W-1:0]   tcb_reg;

    logic signed [62:0]       prod_adj;
    logic signed [62:0]       q_shift;
    logic signed [41:0]       diff_next;
    logic signed [41:0]       diff_reg;
    logic signed [TC_W-1:0]   tcc_reg;

    logic signed [41:0]       diff_adj;
    logic signed [41:0]       p_shift;
    logic [31:0]              press_next;
    logic [31:0]              temp_next;
    logic [31:0]              press_reg;
    logic [31:0]              temp_reg;

    assign stg_en[3] = !vld_reg[3] || out_ready;
    assign stg_en[2] = !vld_reg[2] || stg_en[3];
    assign stg_en[1] = !vld_reg[1] || stg_en[2];
    assign stg_en[0] = !vld_reg[0] || stg_en[1];

    always_comb
    begin
        vld_next = vld_reg;
        if (stg_en[0])
            vld_next[0] = in_valid;
        if (stg_en[1])
            vld_next[1] = vld_reg[0];
        if (stg_en[2])
            vld_next[2] = vld_reg[1];
        if (stg_en[3])
            vld_next[3] = vld_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 4'b0000;
        else
            vld_reg <= vld_next;
    end

    // The sensitivity word is split into an unsigned low half and a signed high half.
    assign pp_lo_next = in_data.d1 * in_data.sens_f[18:0];
    assign pp_hi_next = $signed({1'b0, in_data.d1}) * $signed(in_data.sens_f[SENSF_W-1:19]);

    assign prod_next = $signed({pp_hi_reg, 19'h00000}) + $signed({20'h00000, pp_lo_reg});

    always_comb
    begin
        prod_adj  = prod_reg + (prod_reg[62] ? 63'sd2097151 : 63'sd0);
        q_shift   = prod_adj >>> 21;
        diff_next = $signed(q_shift[41:0])
                    - $signed({{(42-OFFF_W){offb_reg[OFFF_W-1]}}, offb_reg});
    end

    always_comb
    begin
        diff_adj   = diff_reg + (diff_reg[41] ? 42'sd8191 : 42'sd0);
        p_shift    = diff_adj >>> 13;
        press_next = p_shift[31:0];
        temp_next  = {{(32-TC_W){tcc_reg[TC_W-1]}}, tcc_reg};
        if (cfg.press_trim != NO_TRIM)
            press_next = press_next + cfg.press_trim;
        if (cfg.temp_trim != NO_TRIM)
            temp_next = temp_next + cfg.temp_trim;
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[0])
        begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
            offa_reg  <= in_data.off_f;
            tca_reg   <= in_data.tc;
        end
        if (stg_en[1])
        begin
            prod_reg <= prod_next;
            offb_reg <= offa_reg;
            tcb_reg  <= tca_reg;
        end
        if (stg_en[2])
        begin
            diff_reg <= diff_next;
            tcc_reg  <= tcb_reg;
        end
        if (stg_en[3])
        begin
            press_reg <= press_next;
            temp_reg  <= temp_next;
        end
    end

    assign in_ready    = stg_en[0];
    assign out_valid   = vld_reg[3];
    assign temperature = temp_reg;
    assign pressure    = press_reg;

endmodule

// ===== rtl/pressure_temp_compensation_unit.sv =====
// Compensated pressure and temperature from raw conversions: ten register stages.
// A result beat is presented from the output register of the last stage.
// Throughput is one beat per cycle unless the output stalls; each stage holds its own valid bit
// and advances on its own, so a stall at the output only backs up stages that hold data.
// Reset clears every valid bit, the calibration words to zero and both trims to all ones.
// Depends on ptc_pkg, ptc_regs, ptc_front, ptc_second and ptc_press.
module pressure_temp_compensation_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [23:0]               raw_press,
    input  logic [23:0]               raw_temp,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [31:0]        temperature,
    output logic signed [31:0]        pressure,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [ptc_pkg::IDX_W-1:0] cfg_index,
    input  logic [31:0]               cfg_data
);
    import ptc_pkg::*;

    ptc_cfg_t    cfg;
    ptc_first_t  first_data;
    ptc_second_t second_data;
    logic        first_valid;
    logic        first_ready;
    logic        second_valid;
    logic        second_ready;

    assign cfg_ready = 1'b1;

    ptc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ptc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .raw_press (raw_press),
        .raw_temp  (raw_temp),
        .out_valid (first_valid),
        .out_ready (first_ready),
        .out_data  (first_data)
    );

    ptc_second u_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (first_valid),
        .in_ready  (first_ready),
        .in_data   (first_data),
        .out_valid (second_valid),
        .out_ready (second_ready),
        .out_data  (second_data)
    );

    ptc_press u_press (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (second_valid),
        .in_ready    (second_ready),
        .in_data     (second_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .temperature (temperature),
        .pressure    (pressure)
    );

    // A free output lets every stage advance, so the input side must be ready.
    assert property (@(posedge clk) disable iff (!rst_n) out_ready |-> in_ready)
        else $error("input stalled while the output was taking beats");

    assert property (@(posedge clk) disable iff (!rst_n) !out_valid |-> in_ready)
        else $error("input stalled while the output register was empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        second_valid && !second_ready |-> out_valid && !out_ready)
        else $error("final stages stalled without a held result");

endmodule
